// ----- design/tpv_pkg.sv -----
// ---------------------------------------------------------------------------
// tpv_pkg
// Shared types and constants for the timed PWM vibrator block.
// ---------------------------------------------------------------------------
package tpv_pkg;

    // Field widths
    localparam int CMD_W      = 2;
    localparam int DUR_W      = 16;
    localparam int MS_W       = 14;
    localparam int CNT_W      = 12;
    localparam int FREQ_W     = 16;
    localparam int DUTY_W     = 7;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    // Parameter defaults
    localparam int CLOCK_HZ_DEFAULT  = 38400000;
    localparam int MAX_ON_MS_DEFAULT = 15000;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_REQUEST = 2'd0,
        CMD_PWM_TICK = 2'd1,
        CMD_MS_TICK = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PWM_FREQ = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY     = 1'd1;

    // Register limits and reset values
    localparam logic [FREQ_W-1:0] FREQ_MIN   = 16'd10000;
    localparam logic [FREQ_W-1:0] FREQ_MAX   = 16'd50000;
    localparam logic [FREQ_W-1:0] FREQ_RESET = 16'd20000;
    localparam logic [DUTY_W-1:0] DUTY_MIN   = 7'd1;
    localparam logic [DUTY_W-1:0] DUTY_MAX   = 7'd99;
    localparam logic [DUTY_W-1:0] DUTY_RESET = 7'd50;
    localparam logic [DUTY_W-1:0] PERCENT    = 7'd100;

    // Largest counter value
    localparam logic [CNT_W-1:0] CNT_MAX = 12'hFFF;

    // Timing sequencer states
    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_LOAD,
        SEQ_PERIOD,
        SEQ_SCALE,
        SEQ_HIGH
    } seq_state_t;

    // Timing values handed to the datapath
    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] period;
        logic [CNT_W-1:0] low;
    } tpv_timing_t;

endpackage

// ----- design/tpv_req_if.sv -----
// ---------------------------------------------------------------------------
// tpv_req_if
// Request channel: command and duration beats into the vibrator.
// ---------------------------------------------------------------------------
interface tpv_req_if
    import tpv_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [DUR_W-1:0] duration_ms;

    modport source (output valid, output cmd, output duration_ms, input ready);
    modport sink   (input valid, input cmd, input duration_ms, output ready);
endinterface

// ----- design/tpv_res_if.sv -----
// ---------------------------------------------------------------------------
// tpv_res_if
// Result channel: motor status beats out of the vibrator.
// ---------------------------------------------------------------------------
interface tpv_res_if
    import tpv_pkg::*;
;
    logic            valid;
    logic            ready;
    logic            motor_enable;
    logic            pwm_level;
    logic [MS_W-1:0] remaining_ms;

    modport source (output valid, output motor_enable, output pwm_level,
                    output remaining_ms, input ready);
    modport sink   (input valid, input motor_enable, input pwm_level,
                    input remaining_ms, output ready);
endinterface

// ----- design/timed_pwm_vibrator.sv -----
// ---------------------------------------------------------------------------
// timed_pwm_vibrator
// Timed PWM motor driver: on/off requests, PWM and millisecond ticks, one
// status beat per request beat.
// ---------------------------------------------------------------------------
//  Channel  Dir  Payload                                  Handshake
//  req      in   cmd[1:0], duration_ms[15:0]              valid/ready
//  res      out  motor_enable, pwm_level, remaining_ms    valid/ready
//  cfg      in   cfg_index[0], cfg_data[15:0]             cfg_we, no stall
//
//  Each request beat is processed combinationally; its result sits in an output
//  register the cycle after, so a beat can be taken every cycle while res is
//  ready and the timing unit is idle. A held result stalls req only while
//  res.ready is low. A config write while the motor is stopped starts the
//  timing unit (load, DIV_W divide steps, scale, divide by 100), during
//  which req.ready is low.
//  Reset: motor off, period and duty at 20 kHz / 50 percent.
// ---------------------------------------------------------------------------
module timed_pwm_vibrator
    import tpv_pkg::*;
#(
    parameter int CLOCK_HZ  = CLOCK_HZ_DEFAULT,
    parameter int MAX_ON_MS = MAX_ON_MS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    tpv_req_if.sink               req,
    tpv_res_if.source             res,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [DUR_W-1:0] MAX_ON = DUR_W'(MAX_ON_MS);

    tpv_timing_t timing;

    logic            running_reg, running_next;
    logic [MS_W-1:0] ms_left_reg, ms_left_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic            res_valid_reg, res_valid_next;
    logic            res_enable_reg, res_enable_next;
    logic            res_level_reg, res_level_next;
    logic [MS_W-1:0] res_ms_reg, res_ms_next;

    logic             accept;
    logic [DUR_W-1:0] dur_sat;
    logic [CNT_W:0]   cnt_inc;
    logic [MS_W-1:0]  ms_dec;
    cmd_t             cmd;

    // Period and low-time computation
    tpv_timing #(
        .CLOCK_HZ (CLOCK_HZ)
    ) u_timing (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .running   (running_reg),
        .timing    (timing)
    );

    // Take a beat when the timing unit is idle and the output slot frees up
    assign req.ready = !timing.busy && (!res_valid_reg || res.ready);
    assign accept    = req.valid && req.ready;
    assign cmd       = cmd_t'(req.cmd);

    // State update for one beat
    always_comb
    begin
        dur_sat = (req.duration_ms > MAX_ON) ? MAX_ON : req.duration_ms;
        cnt_inc = {1'b0, cnt_reg} + 1'b1;
        ms_dec  = (ms_left_reg != '0) ? (ms_left_reg - 1'b1) : ms_left_reg;

        running_next = running_reg;
        ms_left_next = ms_left_reg;
        cnt_next     = cnt_reg;

        if (accept)
        begin
            unique case (cmd)
                CMD_REQUEST:
                begin
                    if (req.duration_ms == '0)
                    begin
                        running_next = 1'b0;
                        ms_left_next = '0;
                        cnt_next     = '0;
                    end
                    else
                    begin
                        ms_left_next = dur_sat[MS_W-1:0];
                        if (!running_reg)
                        begin
                            running_next = 1'b1;
                            cnt_next     = '0;
                        end
                    end
                end
                CMD_PWM_TICK:
                begin
                    if (running_reg)
                    begin
                        if (cnt_inc >= {1'b0, timing.period} || cnt_inc[CNT_W])
                            cnt_next = '0;
                        else
                            cnt_next = cnt_inc[CNT_W-1:0];
                    end
                end
                CMD_MS_TICK:
                begin
                    if (running_reg)
                    begin
                        ms_left_next = ms_dec;
                        if (ms_dec == '0)
                        begin
                            running_next = 1'b0;
                            cnt_next     = '0;
                        end
                    end
                end
                CMD_NONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // Output register
    always_comb
    begin
        res_valid_next  = res_valid_reg;
        res_enable_next = res_enable_reg;
        res_level_next  = res_level_reg;
        res_ms_next     = res_ms_reg;
        if (res_valid_reg && res.ready)
            res_valid_next = 1'b0;
        if (accept)
        begin
            res_valid_next  = 1'b1;
            res_enable_next = running_next;
            res_level_next  = running_next && (cnt_next >= timing.low);
            res_ms_next     = running_next ? ms_left_next : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg    <= 1'b0;
            ms_left_reg    <= '0;
            cnt_reg        <= '0;
            res_valid_reg  <= 1'b0;
            res_enable_reg <= 1'b0;
            res_level_reg  <= 1'b0;
            res_ms_reg     <= '0;
        end
        else
        begin
            running_reg    <= running_next;
            ms_left_reg    <= ms_left_next;
            cnt_reg        <= cnt_next;
            res_valid_reg  <= res_valid_next;
            res_enable_reg <= res_enable_next;
            res_level_reg  <= res_level_next;
            res_ms_reg     <= res_ms_next;
        end
    end

    assign res.valid        = res_valid_reg;
    assign res.motor_enable = res_enable_reg;
    assign res.pwm_level    = res_level_reg;
    assign res.remaining_ms = res_ms_reg;

endmodule

// ----- design/tpv_timing.sv -----
// ---------------------------------------------------------------------------
// tpv_timing
// Config registers and the PWM timing unit. A bit-serial divider derives the
// period = CLOCK_HZ / freq, then high = period * (100 - duty) / 100 is taken
// by a reciprocal multiply, and the low time is what is left of the period.
// ---------------------------------------------------------------------------
module tpv_timing
    import tpv_pkg::*;
#(
    parameter int CLOCK_HZ = CLOCK_HZ_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  running,
    output tpv_timing_t           timing
);

    localparam int CLK_W  = $clog2(CLOCK_HZ + 1);
    localparam int PROD_W = CNT_W + DUTY_W;
    localparam int DIV_W  = (CLK_W > PROD_W) ? CLK_W : PROD_W;
    localparam int STEP_W = $clog2(DIV_W);
    localparam int REM_W  = FREQ_W + 1;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_W - 1);
    localparam logic [DIV_W-1:0]  CLOCK_DIV = DIV_W'(CLOCK_HZ);

    // Divide by 100 as multiply by ceil(2^RECIP_SH / 100), exact for PROD_W bits
    localparam int RECIP_SH = PROD_W + 7;
    localparam int RECIP_W  = RECIP_SH - 6;
    localparam int HPROD_W  = PROD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SH) + 64'd99) / 64'd100);

    // Reset values of the derived counts
    localparam int PERIOD_RAW = CLOCK_HZ / 20000;
    localparam int PERIOD_RST = (PERIOD_RAW > 4095) ? 4095 : PERIOD_RAW;
    localparam int HIGH_RST   = PERIOD_RST * (100 - 50) / 100;
    localparam logic [CNT_W-1:0] PERIOD_RST_V = CNT_W'(PERIOD_RST);
    localparam logic [CNT_W-1:0] LOW_RST_V    = CNT_W'(PERIOD_RST - HIGH_RST);

    seq_state_t state_reg, state_next;

    logic [FREQ_W-1:0] freq_reg, freq_next;
    logic [DUTY_W-1:0] duty_reg, duty_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [FREQ_W-1:0] divisor_reg, divisor_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0]  period_reg, period_next;
    logic [CNT_W-1:0]  low_reg, low_next;

    logic [REM_W-1:0]   rem_shift;
    logic               rem_ge;
    logic [REM_W-1:0]   rem_step;
    logic [DIV_W-1:0]   quo_step;
    logic [CNT_W-1:0]   period_sat;
    logic [PROD_W-1:0]  scaled;
    logic [HPROD_W-1:0] high_prod;
    logic [FREQ_W-1:0]  freq_clamped;
    logic [DUTY_W-1:0]  duty_raw;
    logic [DUTY_W-1:0]  duty_clamped;

    // Clamp incoming register values
    always_comb
    begin
        duty_raw = cfg_data[DUTY_W-1:0];
        if (cfg_data > FREQ_MAX)
            freq_clamped = FREQ_MAX;
        else if (cfg_data < FREQ_MIN)
            freq_clamped = FREQ_MIN;
        else
            freq_clamped = cfg_data;
        if (duty_raw > DUTY_MAX)
            duty_clamped = DUTY_MAX;
        else if (duty_raw < DUTY_MIN)
            duty_clamped = DUTY_MIN;
        else
            duty_clamped = duty_raw;
    end

    // One restoring division step, the duty scaling and the divide by 100
    always_comb
    begin
        rem_shift = {rem_reg[REM_W-2:0], quo_reg[DIV_W-1]};
        rem_ge    = (rem_shift >= {1'b0, divisor_reg});
        rem_step  = rem_ge ? (rem_shift - {1'b0, divisor_reg}) : rem_shift;
        quo_step  = {quo_reg[DIV_W-2:0], rem_ge};
        period_sat = (quo_step > DIV_W'(CNT_MAX)) ? CNT_MAX : quo_step[CNT_W-1:0];
        scaled    = PROD_W'(period_reg) * PROD_W'(PERCENT - duty_reg);
        high_prod = HPROD_W'(quo_reg[PROD_W-1:0]) * HPROD_W'(RECIP);
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= SEQ_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and datapath
    always_comb
    begin
        state_next   = state_reg;
        freq_next    = freq_reg;
        duty_next    = duty_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        step_next    = step_reg;
        period_next  = period_reg;
        low_next     = low_reg;

        unique case (state_reg)
            SEQ_IDLE:
            begin
            end
            SEQ_LOAD:
            begin
                rem_next     = '0;
                quo_next     = CLOCK_DIV;
                divisor_next = freq_reg;
                step_next    = '0;
                state_next   = SEQ_PERIOD;
            end
            SEQ_PERIOD:
            begin
                rem_next  = rem_step;
                quo_next  = quo_step;
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    period_next = period_sat;
                    state_next  = SEQ_SCALE;
                end
            end
            SEQ_SCALE:
            begin
                quo_next   = DIV_W'(scaled);
                state_next = SEQ_HIGH;
            end
            SEQ_HIGH:
            begin
                low_next   = period_reg - high_prod[RECIP_SH +: CNT_W];
                state_next = SEQ_IDLE;
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase

        // A register write restarts the computation; ignored while running
        if (cfg_we && !running)
        begin
            unique case (cfg_index)
                REG_PWM_FREQ: freq_next = freq_clamped;
                REG_DUTY:     duty_next = duty_clamped;
                default:      freq_next = freq_reg;
            endcase
            state_next = SEQ_LOAD;
        end
    end

    // Datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg    <= FREQ_RESET;
            duty_reg    <= DUTY_RESET;
            period_reg  <= PERIOD_RST_V;
            low_reg     <= LOW_RST_V;
            rem_reg     <= '0;
            quo_reg     <= '0;
            divisor_reg <= FREQ_RESET;
            step_reg    <= '0;
        end
        else
        begin
            freq_reg    <= freq_next;
            duty_reg    <= duty_next;
            period_reg  <= period_next;
            low_reg     <= low_next;
            rem_reg     <= rem_next;
            quo_reg     <= quo_next;
            divisor_reg <= divisor_next;
            step_reg    <= step_next;
        end
    end

    assign timing.busy   = (state_reg != SEQ_IDLE);
    assign timing.period = period_reg;
    assign timing.low    = low_reg;

endmodule
